@@ rtl/pooled_deque_sorted_free_list_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the pooled deque block.
// Shared helpers that keep the concurrent checks short and uniform.
// ---------------------------------------------------------------------------
`ifndef POOLED_DEQUE_SORTED_FREE_LIST_TOP_DEFINES_SVH
`define POOLED_DEQUE_SORTED_FREE_LIST_TOP_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define PDSFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define PDSFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pdsfl_pkg.sv @@
// ---------------------------------------------------------------------------
// pdsfl_pkg
// Codes, field widths and sequencer states of the pooled deque block.
// ---------------------------------------------------------------------------
package pdsfl_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PUSH_W   = 32;
  localparam int unsigned TAKEN_W  = 32;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_LINK,
    ST_TAKE,
    ST_TAKE_LINK,
    ST_GIVE_LO,
    ST_GIVE_HI,
    ST_WALK,
    ST_LINK_SELF,
    ST_LINK_NBR
  } state_e;

endpackage

@@ rtl/pooled_deque_sorted_free_list_top.sv @@
// ---------------------------------------------------------------------------
// pooled_deque_sorted_free_list_top
// Double-ended queue of values held in a pool of linked cells.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. kind_i selects a push
// at the rear, a take from the front or a take from the rear; push_value_i
// carries the value of a push. Each item of a valid kind produces one result,
// shown for one cycle while done_o is high: taken_value_o, cell_index_o and
// status_o. The receiver cannot stall; the result is gone after that cycle.
// A push into a full pool or a take from an empty queue reports its status in
// the cycle after acceptance. A successful push reports from ST_PUSH_LINK.
// A take frees its cell into an ascending free list. It goes to the
// low end when the list is empty or the cell lies below its first cell, to the
// high end when it lies above its last cell, and otherwise after a walk over
// the next-link memory that steps past each free cell below it.
// busy falls in the cycle in which done_o rises, so items may follow directly.
// After reset the block runs a clearing pass that links every cell but cell 0,
// the null link, into the free list; busy is high meanwhile.
// ---------------------------------------------------------------------------
module pooled_deque_sorted_free_list_top #(
  parameter int unsigned POOL_CELLS = 256,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pdsfl_pkg::KIND_W-1:0]      kind_i,
  input  logic [pdsfl_pkg::PUSH_W-1:0]      push_value_i,
  output logic                              done_o,
  output logic [pdsfl_pkg::TAKEN_W-1:0]     taken_value_o,
  output logic [pdsfl_pkg::CELL_W-1:0]      cell_index_o,
  output logic [pdsfl_pkg::STATUS_W-1:0]    status_o
);

  import pdsfl_pkg::*;

  localparam int unsigned IW = $clog2(POOL_CELLS);

  logic                  val_we;
  logic [IW-1:0]         val_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [IW-1:0]         val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  nxt_we;
  logic [IW-1:0]         nxt_waddr;
  logic [IW-1:0]         nxt_wdata;
  logic [IW-1:0]         nxt_raddr;
  logic [IW-1:0]         nxt_rdata;
  logic                  prv_we;
  logic [IW-1:0]         prv_waddr;
  logic [IW-1:0]         prv_wdata;
  logic [IW-1:0]         prv_raddr;
  logic [IW-1:0]         prv_rdata;

  pdsfl_ram #(
    .DEPTH (POOL_CELLS),
    .WIDTH (VALUE_BITS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  pdsfl_ram #(
    .DEPTH (POOL_CELLS),
    .WIDTH (IW)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  pdsfl_ram #(
    .DEPTH (POOL_CELLS),
    .WIDTH (IW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (prv_raddr),
    .rdata_o (prv_rdata)
  );

  pdsfl_ctrl #(
    .POOL_CELLS (POOL_CELLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .taken_value_o (taken_value_o),
    .cell_index_o  (cell_index_o),
    .status_o      (status_o),
    .val_we_o      (val_we),
    .val_waddr_o   (val_waddr),
    .val_wdata_o   (val_wdata),
    .val_raddr_o   (val_raddr),
    .val_rdata_i   (val_rdata),
    .nxt_we_o      (nxt_we),
    .nxt_waddr_o   (nxt_waddr),
    .nxt_wdata_o   (nxt_wdata),
    .nxt_raddr_o   (nxt_raddr),
    .nxt_rdata_i   (nxt_rdata),
    .prv_we_o      (prv_we),
    .prv_waddr_o   (prv_waddr),
    .prv_wdata_o   (prv_wdata),
    .prv_raddr_o   (prv_raddr),
    .prv_rdata_i   (prv_rdata)
  );

endmodule

@@ rtl/pdsfl_ram.sv @@
// ---------------------------------------------------------------------------
// pdsfl_ram
// Single-port-write, single-port-read memory with registered read data.
// ---------------------------------------------------------------------------
module pdsfl_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pdsfl_ctrl.sv @@
// ---------------------------------------------------------------------------
// pdsfl_ctrl
// Sequencer of the pooled deque: link updates, free-list walk, shared compare.
// ---------------------------------------------------------------------------
`include "pooled_deque_sorted_free_list_top_defines.svh"

module pdsfl_ctrl #(
  parameter int unsigned POOL_CELLS = 256,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned IW = $clog2(POOL_CELLS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pdsfl_pkg::KIND_W-1:0]      kind_i,
  input  logic [pdsfl_pkg::PUSH_W-1:0]      push_value_i,
  output logic                              done_o,
  output logic [pdsfl_pkg::TAKEN_W-1:0]     taken_value_o,
  output logic [pdsfl_pkg::CELL_W-1:0]      cell_index_o,
  output logic [pdsfl_pkg::STATUS_W-1:0]    status_o,
  output logic                              val_we_o,
  output logic [IW-1:0]                     val_waddr_o,
  output logic [VALUE_BITS-1:0]             val_wdata_o,
  output logic [IW-1:0]                     val_raddr_o,
  input  logic [VALUE_BITS-1:0]             val_rdata_i,
  output logic                              nxt_we_o,
  output logic [IW-1:0]                     nxt_waddr_o,
  output logic [IW-1:0]                     nxt_wdata_o,
  output logic [IW-1:0]                     nxt_raddr_o,
  input  logic [IW-1:0]                     nxt_rdata_i,
  output logic                              prv_we_o,
  output logic [IW-1:0]                     prv_waddr_o,
  output logic [IW-1:0]                     prv_wdata_o,
  output logic [IW-1:0]                     prv_raddr_o,
  input  logic [IW-1:0]                     prv_rdata_i
);

  import pdsfl_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(POOL_CELLS - 1);
  localparam logic [IW-1:0] ONE  = IW'(1);

  state_e state_q, state_d;

  logic [IW-1:0]         clr_q, clr_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [IW-1:0]         p_q, p_d;
  logic [IW-1:0]         lo_q, lo_d;
  logic [IW-1:0]         hi_q, hi_d;
  logic [IW-1:0]         front_q, front_d;
  logic [IW-1:0]         rear_q, rear_d;
  logic [IW-1:0]         ffirst_q, ffirst_d;
  logic [IW-1:0]         flast_q, flast_d;
  logic                  done_q, done_d;
  logic [VALUE_BITS-1:0] taken_q, taken_d;
  logic [IW-1:0]         cell_q, cell_d;
  logic [STATUS_W-1:0]   status_q, status_d;

  logic [IW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  // One shared magnitude comparator serves every ordering decision.
  always_comb begin
    unique case (state_q)
      ST_GIVE_HI: begin
        cmp_a = flast_q;
        cmp_b = idx_q;
      end
      ST_WALK: begin
        cmp_a = nxt_rdata_i;
        cmp_b = idx_q;
      end
      default: begin
        cmp_a = idx_q;
        cmp_b = ffirst_q;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (kind_i)
            KIND_PUSH: begin
              if (ffirst_q != '0) begin
                state_d = ST_PUSH;
              end
            end
            KIND_SHIFT, KIND_POP: begin
              if (front_q != '0) begin
                state_d = ST_TAKE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:      state_d = ST_PUSH_LINK;
      ST_PUSH_LINK: state_d = ST_IDLE;
      ST_TAKE:      state_d = ST_TAKE_LINK;
      ST_TAKE_LINK: state_d = ST_GIVE_LO;
      ST_GIVE_LO: begin
        if (ffirst_q == '0 || cmp_lt) begin
          state_d = ST_LINK_SELF;
        end else begin
          state_d = ST_GIVE_HI;
        end
      end
      ST_GIVE_HI: begin
        if (cmp_lt) begin
          state_d = ST_LINK_SELF;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!(nxt_rdata_i != '0 && cmp_lt)) begin
          state_d = ST_LINK_SELF;
        end
      end
      ST_LINK_SELF: state_d = ST_LINK_NBR;
      ST_LINK_NBR:  state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_d    = clr_q;
    kind_d   = kind_q;
    val_d    = val_q;
    idx_d    = idx_q;
    p_d      = p_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    front_d  = front_q;
    rear_d   = rear_q;
    ffirst_d = ffirst_q;
    flast_d  = flast_q;
    done_d   = 1'b0;
    taken_d  = taken_q;
    cell_d   = cell_q;
    status_d = status_q;

    val_we_o    = 1'b0;
    val_waddr_o = idx_q;
    val_wdata_o = val_q;
    val_raddr_o = idx_q;
    nxt_we_o    = 1'b0;
    nxt_waddr_o = idx_q;
    nxt_wdata_o = '0;
    nxt_raddr_o = idx_q;
    prv_we_o    = 1'b0;
    prv_waddr_o = idx_q;
    prv_wdata_o = '0;
    prv_raddr_o = idx_q;

    unique case (state_q)
      ST_CLEAR: begin
        nxt_we_o    = 1'b1;
        nxt_waddr_o = clr_q;
        nxt_wdata_o = (clr_q == LAST || clr_q == '0) ? '0 : IW'(clr_q + ONE);
        prv_we_o    = 1'b1;
        prv_waddr_o = clr_q;
        prv_wdata_o = (clr_q == '0) ? '0 : IW'(clr_q - ONE);
        clr_d       = IW'(clr_q + ONE);
      end
      ST_IDLE: begin
        if (start) begin
          kind_d = kind_i;
          val_d  = VALUE_BITS'(push_value_i);
          unique case (kind_i)
            KIND_PUSH: begin
              if (ffirst_q == '0) begin
                done_d   = 1'b1;
                taken_d  = '0;
                cell_d   = '0;
                status_d = STATUS_FULL;
              end else begin
                idx_d = ffirst_q;
              end
            end
            KIND_SHIFT, KIND_POP: begin
              if (front_q == '0) begin
                done_d   = 1'b1;
                taken_d  = '0;
                cell_d   = '0;
                status_d = STATUS_EMPTY;
              end else begin
                idx_d = (kind_i == KIND_SHIFT) ? front_q : rear_q;
              end
            end
            default: idx_d = idx_q;
          endcase
        end
      end
      ST_PUSH: begin
        val_we_o    = 1'b1;
        prv_we_o    = 1'b1;
        prv_wdata_o = rear_q;
        nxt_we_o    = (rear_q != '0);
        nxt_waddr_o = rear_q;
        nxt_wdata_o = idx_q;
      end
      ST_PUSH_LINK: begin
        ffirst_d = nxt_rdata_i;
        if (nxt_rdata_i == '0) begin
          flast_d = '0;
        end else begin
          prv_we_o    = 1'b1;
          prv_waddr_o = nxt_rdata_i;
        end
        nxt_we_o = 1'b1;
        if (front_q == '0) begin
          front_d = idx_q;
        end
        rear_d   = idx_q;
        done_d   = 1'b1;
        taken_d  = '0;
        cell_d   = idx_q;
        status_d = STATUS_DONE;
      end
      ST_TAKE: begin
        taken_d = taken_q;
      end
      ST_TAKE_LINK: begin
        taken_d = val_rdata_i;
        if (kind_q == KIND_SHIFT) begin
          front_d = nxt_rdata_i;
          if (nxt_rdata_i != '0) begin
            prv_we_o    = 1'b1;
            prv_waddr_o = nxt_rdata_i;
          end else begin
            rear_d = '0;
          end
        end else begin
          rear_d = prv_rdata_i;
          if (prv_rdata_i != '0) begin
            nxt_we_o    = 1'b1;
            nxt_waddr_o = prv_rdata_i;
          end else begin
            front_d = '0;
          end
        end
      end
      ST_GIVE_LO: begin
        if (ffirst_q == '0) begin
          lo_d = '0;
          hi_d = '0;
        end else if (cmp_lt) begin
          lo_d = '0;
          hi_d = ffirst_q;
        end
      end
      ST_GIVE_HI: begin
        if (cmp_lt) begin
          lo_d = flast_q;
          hi_d = '0;
        end else begin
          p_d         = ffirst_q;
          nxt_raddr_o = ffirst_q;
        end
      end
      ST_WALK: begin
        if (nxt_rdata_i != '0 && cmp_lt) begin
          p_d         = nxt_rdata_i;
          nxt_raddr_o = nxt_rdata_i;
        end else if (nxt_rdata_i == '0) begin
          lo_d = flast_q;
          hi_d = '0;
        end else begin
          lo_d = p_q;
          hi_d = nxt_rdata_i;
        end
      end
      ST_LINK_SELF: begin
        nxt_we_o    = 1'b1;
        nxt_wdata_o = hi_q;
        prv_we_o    = 1'b1;
        prv_wdata_o = lo_q;
      end
      ST_LINK_NBR: begin
        if (lo_q != '0) begin
          nxt_we_o    = 1'b1;
          nxt_waddr_o = lo_q;
          nxt_wdata_o = idx_q;
        end else begin
          ffirst_d = idx_q;
        end
        if (hi_q != '0) begin
          prv_we_o    = 1'b1;
          prv_waddr_o = hi_q;
          prv_wdata_o = idx_q;
        end else begin
          flast_d = idx_q;
        end
        done_d   = 1'b1;
        cell_d   = idx_q;
        status_d = STATUS_DONE;
      end
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      front_q  <= '0;
      rear_q   <= '0;
      ffirst_q <= ONE;
      flast_q  <= LAST;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      front_q  <= front_d;
      rear_q   <= rear_d;
      ffirst_q <= ffirst_d;
      flast_q  <= flast_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    p_q      <= p_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    taken_q  <= taken_d;
    cell_q   <= cell_d;
    status_q <= status_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign taken_value_o = TAKEN_W'(taken_q);
  assign cell_index_o  = CELL_W'(cell_q);
  assign status_o      = status_q;

  `PDSFL_ASSERT_IMP(a_clear_quiet, clk_i, rst_ni, state_q == ST_CLEAR, !done_q, "Result during clear.")
  `PDSFL_ASSERT_IMP(a_queue_ends, clk_i, rst_ni, (front_q == '0) != (rear_q == '0), 1'b0, "Queue ends disagree.")
  `PDSFL_ASSERT_IMP(a_free_ends, clk_i, rst_ni, (ffirst_q == '0) != (flast_q == '0), 1'b0, "Free list ends disagree.")
  `PDSFL_ASSERT_NXT(a_push_busy, clk_i, rst_ni, start && !busy && kind_i == KIND_PUSH && ffirst_q != '0, busy && !done_q, "Push did not start.")

endmodule
